// File: rtl/ole_pkg.sv
package ole_pkg;

    // List geometry
    localparam int CAPACITY   = 16;
    localparam int DATA_WIDTH = 32;
    localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W      = $clog2(CAPACITY + 1);

    // Port field widths
    localparam int KIND_W     = 3;
    localparam int KEY_W      = 32;
    localparam int VALUE_W    = 32;
    localparam int INDEX_W    = 4;
    localparam int STATUS_W   = 2;
    localparam int POSITION_W = 4;
    localparam int RDATA_W    = 32;
    localparam int COUNT_W    = 5;

    // Width used to compare a request index with the live count
    localparam int CMP_W      = INDEX_W + CNT_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND  = 3'd0,
        KIND_PREPEND = 3'd1,
        KIND_FIND    = 3'd2,
        KIND_DELETE  = 3'd3,
        KIND_INSERT  = 3'd4,
        KIND_READ    = 3'd5,
        KIND_WRITE   = 3'd6
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    // What one cell does in a cycle
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_LOAD       = 2'd1,
        CELL_TAKE_LOWER = 2'd2,
        CELL_TAKE_UPPER = 2'd3
    } cell_op_t;

    // What the whole row does in a cycle
    typedef enum logic [1:0] {
        MODE_HOLD  = 2'd0,
        MODE_LOAD  = 2'd1,
        MODE_OPEN  = 2'd2,
        MODE_CLOSE = 2'd3
    } chain_mode_t;

    typedef struct packed {
        chain_mode_t            mode;
        logic [IDX_W-1:0]       pos;
    } chain_cmd_t;

    typedef struct packed {
        logic                   hit;
        logic [IDX_W-1:0]       hit_pos;
    } match_info_t;

endpackage

// File: rtl/ordered_list_engine_top.sv
// Ordered list engine: a row of cells holding up to CAPACITY words in order.
// Result strobe: done rises in the cycle after start is taken.
// Throughput: one request per cycle; every kind finishes in the row of cells
// in the cycle it is taken, so busy stays low.
// Reset: rst_n clears the live count and the strobe; entries stay undefined
// until written. Results cannot be stalled by the receiver.
module ordered_list_engine_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [ole_pkg::KIND_W-1:0]      kind,
    input  logic [ole_pkg::KEY_W-1:0]       key,
    input  logic [ole_pkg::VALUE_W-1:0]     value,
    input  logic [ole_pkg::INDEX_W-1:0]     index,
    output logic                            done,
    output logic [ole_pkg::STATUS_W-1:0]    status,
    output logic [ole_pkg::POSITION_W-1:0]  position,
    output logic [ole_pkg::RDATA_W-1:0]     read_data,
    output logic [ole_pkg::COUNT_W-1:0]     count
);
    import ole_pkg::*;

    logic                   accept;
    logic                   full;
    logic                   idx_ok;
    logic [DATA_WIDTH-1:0]  key_d;
    logic [DATA_WIDTH-1:0]  value_d;
    logic [IDX_W-1:0]       idx_sel;
    logic [DATA_WIDTH-1:0]  rd_entry;
    match_info_t            info;
    chain_cmd_t             cmd;

    logic [CNT_W-1:0]       cnt_reg;
    logic [CNT_W-1:0]       cnt_next;
    logic                   done_reg;
    status_t                status_reg;
    status_t                status_next;
    logic [IDX_W-1:0]       pos_reg;
    logic [IDX_W-1:0]       pos_next;
    logic [RDATA_W-1:0]     rdata_reg;
    logic [RDATA_W-1:0]     rdata_next;

    // Every request completes in the cycle it is taken
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Cut request words to the stored width
    assign key_d   = DATA_WIDTH'(key);
    assign value_d = DATA_WIDTH'(value);
    assign idx_sel = IDX_W'(index);
    assign full    = (cnt_reg == CNT_W'(CAPACITY));
    assign idx_ok  = CMP_W'(index) < CMP_W'(cnt_reg);

    ole_chain u_chain (
        .clk      (clk),
        .cmd      (cmd),
        .cnt      (cnt_reg),
        .key      (key_d),
        .value    (value_d),
        .rd_idx   (idx_sel),
        .info     (info),
        .rd_entry (rd_entry)
    );

    // Decode the transaction into a row command and its result
    always_comb
    begin
        cmd.mode    = MODE_HOLD;
        cmd.pos     = '0;
        cnt_next    = cnt_reg;
        status_next = ST_OK;
        pos_next    = '0;
        rdata_next  = '0;
        if (accept)
        begin
            case (kind_t'(kind))
                KIND_APPEND:
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        cmd.mode = MODE_LOAD;
                        cmd.pos  = IDX_W'(cnt_reg);
                        pos_next = IDX_W'(cnt_reg);
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                KIND_PREPEND:
                    if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        cmd.mode = MODE_OPEN;
                        cmd.pos  = '0;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                KIND_FIND:
                    if (!info.hit)
                        status_next = ST_MISS;
                    else
                    begin
                        pos_next   = info.hit_pos;
                        rdata_next = RDATA_W'(key_d);
                    end
                KIND_DELETE:
                    if (!info.hit)
                        status_next = ST_MISS;
                    else
                    begin
                        cmd.mode = MODE_CLOSE;
                        cmd.pos  = info.hit_pos;
                        pos_next = info.hit_pos;
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                KIND_INSERT:
                    if (!info.hit)
                        status_next = ST_MISS;
                    else if (full)
                        status_next = ST_FULL;
                    else
                    begin
                        cmd.mode = MODE_OPEN;
                        cmd.pos  = info.hit_pos;
                        pos_next = info.hit_pos;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                KIND_READ:
                    if (!idx_ok)
                        status_next = ST_RANGE;
                    else
                    begin
                        pos_next   = idx_sel;
                        rdata_next = RDATA_W'(rd_entry);
                    end
                KIND_WRITE:
                    if (!idx_ok)
                        status_next = ST_RANGE;
                    else
                    begin
                        cmd.mode = MODE_LOAD;
                        cmd.pos  = idx_sel;
                        pos_next = idx_sel;
                    end
                default:
                    status_next = ST_OK;
            endcase
        end
    end

    // Advance the live count and the strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= accept;
        end
    end

    // Hold the result fields for the strobe cycle
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg <= status_next;
            pos_reg    <= pos_next;
            rdata_reg  <= rdata_next;
        end
    end

    assign done      = done_reg;
    assign status    = status_reg;
    assign position  = POSITION_W'(pos_reg);
    assign read_data = rdata_reg;
    assign count     = COUNT_W'(cnt_reg);

    // Every taken transaction yields exactly one strobe in the following cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("no result after a taken transaction");

    a_no_stray_done: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> !done)
        else $error("result without a transaction");

    // A refusal on a full list leaves the count alone
    a_full_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == ST_FULL) |-> cnt_reg == $past(cnt_reg))
        else $error("count moved on a full refusal");

    // An append into a list with room grows it by one
    a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind_t'(kind) == KIND_APPEND && !full)
            |=> cnt_reg == $past(cnt_reg) + CNT_W'(1))
        else $error("append did not grow the list");

    // A miss reports position zero and no data
    a_miss_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == ST_MISS) |-> (pos_reg == '0 && rdata_reg == '0))
        else $error("miss carried position or data");

endmodule

// File: rtl/ole_cell.sv
module ole_cell (
    input  logic                            clk,
    input  ole_pkg::cell_op_t               op,
    input  logic                            live,
    input  logic [ole_pkg::DATA_WIDTH-1:0]  key,
    input  logic [ole_pkg::DATA_WIDTH-1:0]  value,
    input  logic [ole_pkg::DATA_WIDTH-1:0]  lower,
    input  logic [ole_pkg::DATA_WIDTH-1:0]  upper,
    output logic [ole_pkg::DATA_WIDTH-1:0]  entry,
    output logic                            match
);
    import ole_pkg::*;

    logic [DATA_WIDTH-1:0] entry_reg;
    logic [DATA_WIDTH-1:0] entry_next;

    // Select the new entry: keep, load, or take a neighbor's word
    always_comb
    begin
        case (op)
            CELL_HOLD:       entry_next = entry_reg;
            CELL_LOAD:       entry_next = value;
            CELL_TAKE_LOWER: entry_next = lower;
            CELL_TAKE_UPPER: entry_next = upper;
            default:         entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // Flag a live entry equal to the key
    assign match = live && (entry_reg == key);
    assign entry = entry_reg;

endmodule

// File: rtl/ole_chain.sv
module ole_chain (
    input  logic                            clk,
    input  ole_pkg::chain_cmd_t             cmd,
    input  logic [ole_pkg::CNT_W-1:0]       cnt,
    input  logic [ole_pkg::DATA_WIDTH-1:0]  key,
    input  logic [ole_pkg::DATA_WIDTH-1:0]  value,
    input  logic [ole_pkg::IDX_W-1:0]       rd_idx,
    output ole_pkg::match_info_t            info,
    output logic [ole_pkg::DATA_WIDTH-1:0]  rd_entry
);
    import ole_pkg::*;

    logic [DATA_WIDTH-1:0] entry_q [CAPACITY];
    logic [CAPACITY-1:0]   match;

    genvar i;
    generate
        for (i = 0; i < CAPACITY; i++)
        begin : g_cell
            cell_op_t              op;
            logic                  live;
            logic [DATA_WIDTH-1:0] lower;
            logic [DATA_WIDTH-1:0] upper;

            assign live = CNT_W'(i) < cnt;

            // Bottom cell has no lower neighbor, top cell no upper one
            if (i == 0)
            begin : g_bottom
                assign lower = '0;
            end
            else
            begin : g_lower
                assign lower = entry_q[i-1];
            end

            if (i == CAPACITY - 1)
            begin : g_top
                assign upper = entry_q[i];
            end
            else
            begin : g_upper
                assign upper = entry_q[i+1];
            end

            // Decode this cell's share of the row command
            always_comb
            begin
                case (cmd.mode)
                    MODE_HOLD:
                        op = CELL_HOLD;
                    MODE_LOAD:
                        op = (IDX_W'(i) == cmd.pos) ? CELL_LOAD : CELL_HOLD;
                    MODE_OPEN:
                        if (IDX_W'(i) == cmd.pos)
                            op = CELL_LOAD;
                        else if (IDX_W'(i) > cmd.pos)
                            op = CELL_TAKE_LOWER;
                        else
                            op = CELL_HOLD;
                    MODE_CLOSE:
                        op = (IDX_W'(i) >= cmd.pos) ? CELL_TAKE_UPPER : CELL_HOLD;
                    default:
                        op = CELL_HOLD;
                endcase
            end

            ole_cell u_cell (
                .clk   (clk),
                .op    (op),
                .live  (live),
                .key   (key),
                .value (value),
                .lower (lower),
                .upper (upper),
                .entry (entry_q[i]),
                .match (match[i])
            );
        end
    endgenerate

    // Pick the lowest matching cell
    always_comb
    begin
        info.hit     = |match;
        info.hit_pos = '0;
        for (int j = CAPACITY - 1; j >= 0; j--)
        begin
            if (match[j])
                info.hit_pos = IDX_W'(j);
        end
    end

    // Read one entry by index
    assign rd_entry = entry_q[rd_idx];

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import ole_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [STATUS_W-1:0]   status;
        logic [POSITION_W-1:0] position;
        logic [RDATA_W-1:0]    read_data;
        logic [COUNT_W-1:0]    count;
    } list_resp_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [KIND_W-1:0]     kind = '0;
    logic [KEY_W-1:0]      key = '0;
    logic [VALUE_W-1:0]    value = '0;
    logic [INDEX_W-1:0]    index = '0;
    logic                  busy;
    logic                  done;
    logic [STATUS_W-1:0]   status;
    logic [POSITION_W-1:0] position;
    logic [RDATA_W-1:0]    read_data;
    logic [COUNT_W-1:0]    count;

    // List contents as the block should hold them
    logic [DATA_WIDTH-1:0] list_words [CAPACITY];
    int                    list_len = 0;

    list_resp_t expected_results[$];
    int         mismatch_count = 0;
    int         cycle_count = 0;

    ordered_list_engine_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .kind      (kind),
        .key       (key),
        .value     (value),
        .index     (index),
        .done      (done),
        .status    (status),
        .position  (position),
        .read_data (read_data),
        .count     (count)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("ordered_list_engine_top test failed");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] seen);
        begin
            $display("%0t: mismatch on %s: expected %h, got %h", $realtime, what, want, seen);
            mismatch_count++;
        end
    endtask

    // Apply one request to the list copy and return the result it should give
    function automatic list_resp_t apply_list_request(input logic [KIND_W-1:0] rq_kind,
                                                      input logic [KEY_W-1:0] rq_key,
                                                      input logic [VALUE_W-1:0] rq_value,
                                                      input logic [INDEX_W-1:0] rq_index);
        list_resp_t r;
        int hit;
        r.status    = ST_OK;
        r.position  = '0;
        r.read_data = '0;
        hit = CAPACITY;
        // find the first live entry equal to the key
        for (int i = list_len - 1; i >= 0; i--)
            if (list_words[i] == rq_key)
                hit = i;
        case (rq_kind)
            KIND_APPEND:
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    list_words[list_len] = rq_value;
                    r.position = POSITION_W'(list_len);
                    list_len++;
                end
            KIND_PREPEND:
                if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = list_len; i > 0; i--)
                        list_words[i] = list_words[i-1];
                    list_words[0] = rq_value;
                    list_len++;
                end
            KIND_FIND:
                if (hit >= CAPACITY)
                    r.status = ST_MISS;
                else
                begin
                    r.position  = POSITION_W'(hit);
                    r.read_data = list_words[hit];
                end
            KIND_DELETE:
                if (hit >= CAPACITY)
                    r.status = ST_MISS;
                else
                begin
                    for (int i = hit; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    r.position = POSITION_W'(hit);
                end
            KIND_INSERT:
                // a missing key wins over a full list
                if (hit >= CAPACITY)
                    r.status = ST_MISS;
                else if (list_len >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    for (int i = list_len; i > hit; i--)
                        list_words[i] = list_words[i-1];
                    list_words[hit] = rq_value;
                    list_len++;
                    r.position = POSITION_W'(hit);
                end
            KIND_READ:
                if (rq_index >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    r.read_data = list_words[rq_index];
                    r.position  = rq_index;
                end
            KIND_WRITE:
                if (rq_index >= list_len)
                    r.status = ST_RANGE;
                else
                begin
                    list_words[rq_index] = rq_value;
                    r.position = rq_index;
                end
            default:
                ;
        endcase
        r.count = COUNT_W'(list_len);
        return r;
    endfunction

    // Hold one request until it is taken, then log what it should return
    task automatic send_request(input logic [KIND_W-1:0] rq_kind,
                                input logic [KEY_W-1:0] rq_key,
                                input logic [VALUE_W-1:0] rq_value,
                                input logic [INDEX_W-1:0] rq_index);
        begin
            start <= 1'b1;
            kind  <= rq_kind;
            key   <= rq_key;
            value <= rq_value;
            index <= rq_index;
            @(posedge clk);
            while (busy !== 1'b0)
                @(posedge clk);
            expected_results.push_back(apply_list_request(rq_kind, rq_key, rq_value,
                                                          rq_index));
        end
    endtask

    // Drop start for a random burst, with junk on the request fields
    task automatic idle_burst();
        begin
            start <= 1'b0;
            kind  <= KIND_W'($urandom);
            key   <= $urandom;
            value <= $urandom;
            index <= INDEX_W'($urandom);
            repeat ($urandom_range(1, 15))
                @(posedge clk);
        end
    endtask

    task automatic wait_for_drain();
        begin
            start <= 1'b0;
            while (expected_results.size() != 0)
                @(posedge clk);
        end
    endtask

    // Data words with plenty of duplicates and both ends of the range
    function automatic logic [DATA_WIDTH-1:0] pick_word();
        case ($urandom_range(0, 3))
            0:       return DATA_WIDTH'($urandom_range(0, 7));
            1:       return {{(DATA_WIDTH-3){1'b1}}, 3'($urandom_range(0, 7))};
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    // Compare each result with the oldest pending one
    always @(posedge clk)
    begin : check_results
        list_resp_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with none pending", 32'd0, 32'd0);
            else
            begin
                want = expected_results.pop_front();
                if (status !== want.status)
                    report_mismatch("status", 32'(want.status), 32'(status));
                if (position !== want.position)
                    report_mismatch("position", 32'(want.position), 32'(position));
                if (read_data !== want.read_data)
                    report_mismatch("read_data", want.read_data, read_data);
                if (count !== want.count)
                    report_mismatch("count", 32'(want.count), 32'(count));
            end
        end
    end

    // Lookups and reads on an empty list, plus the unused kind
    task automatic test_empty_list();
        begin
            send_request(KIND_FIND, 32'h0000_0000, 32'h0, 4'd0);
            send_request(KIND_DELETE, 32'hFFFF_FFFF, 32'h0, 4'd0);
            send_request(KIND_READ, 32'h0, 32'h0, 4'd0);
            send_request(KIND_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
        end
    endtask

    // Fill to capacity, then push against the full list
    task automatic test_full_list();
        begin
            send_request(KIND_PREPEND, 32'h0, 32'hFFFF_FFFF, 4'd0);
            send_request(KIND_APPEND, 32'h0, 32'h0000_0000, 4'd0);
            for (int i = 2; i < CAPACITY; i++)
                send_request(KIND_APPEND, 32'h0, 32'hA5A5_0000 | i, 4'd0);
            send_request(KIND_APPEND, 32'h0, 32'h1111_1111, 4'd0);
            send_request(KIND_PREPEND, 32'h0, 32'h2222_2222, 4'd0);
            send_request(KIND_INSERT, 32'h0000_0000, 32'h3333_3333, 4'd0);
            // absent key on a full list reports the miss
            send_request(KIND_INSERT, 32'h1234_5678, 32'h4444_4444, 4'd0);
        end
    endtask

    // Top index, then delete closing the gap
    task automatic test_index_edges();
        begin
            send_request(KIND_READ, 32'h0, 32'h0, 4'd15);
            send_request(KIND_WRITE, 32'h0, 32'h0000_0000, 4'd15);
            send_request(KIND_DELETE, 32'h0000_0000, 32'h0, 4'd0);
        end
    endtask

    // Mixed traffic that alternates between growing and shrinking the list
    task automatic test_random_traffic(input int n_items, input bit with_gaps);
        logic [KIND_W-1:0]     rq_kind;
        logic [KEY_W-1:0]      rq_key;
        logic [INDEX_W-1:0]    rq_index;
        int                    roll;
        bit                    growing;
        begin
            growing = 1'b1;
            for (int n = 0; n < n_items; n++)
            begin
                if (n % 30 == 29)
                    growing = !growing;
                roll = $urandom_range(0, 99);
                if (growing)
                    rq_kind = (roll < 30) ? KIND_APPEND  : (roll < 45) ? KIND_PREPEND :
                              (roll < 60) ? KIND_INSERT  : (roll < 68) ? KIND_FIND    :
                              (roll < 75) ? KIND_DELETE  : (roll < 85) ? KIND_READ    :
                              (roll < 96) ? KIND_WRITE   : KIND_UNUSED;
                else
                    rq_kind = (roll < 10) ? KIND_APPEND  : (roll < 15) ? KIND_PREPEND :
                              (roll < 22) ? KIND_INSERT  : (roll < 35) ? KIND_FIND    :
                              (roll < 65) ? KIND_DELETE  : (roll < 78) ? KIND_READ    :
                              (roll < 96) ? KIND_WRITE   : KIND_UNUSED;
                // mostly keys that are in the list, so matches happen
                if (list_len > 0 && $urandom_range(0, 3) != 0)
                    rq_key = list_words[$urandom_range(0, list_len - 1)];
                else
                    rq_key = pick_word();
                if (list_len > 0 && $urandom_range(0, 2) != 0)
                    rq_index = INDEX_W'($urandom_range(0, list_len - 1));
                else
                    rq_index = INDEX_W'($urandom_range(0, 15));
                send_request(rq_kind, rq_key, pick_word(), rq_index);
                if (with_gaps && $urandom_range(0, 3) == 0)
                    idle_burst();
            end
        end
    endtask

    // Hold off the sender until every result is back
    task automatic test_drain_pause();
        begin
            wait_for_drain();
        end
    endtask

    initial
    begin
        repeat (6)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_full_list();
        test_index_edges();
        test_random_traffic(200, 1'b1);
        test_drain_pause();
        test_random_traffic(150, 1'b1);
        test_random_traffic(100, 1'b0);

        wait_for_drain();
        repeat (4)
            @(posedge clk);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("ordered_list_engine_top test passed");
        else
            $display("ordered_list_engine_top test failed");
        $finish;
    end

endmodule
